@@ hw/rtl/dppe_pkg.sv @@
// ----------------------------------------------------------------------------
// dppe_pkg: shared definitions for the debounced power path enable block
// Widths, register indexes, reset values, command codes and the register
// bank type shared by all modules of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package dppe_pkg;

  // Width of each debounce counter.
  localparam int COUNT_WIDTH = 8;
  // Width of a tick threshold register.
  localparam int TICKS_WIDTH = 8;
  // Width used to compare a threshold against the counter range.
  localparam int CMP_WIDTH = (COUNT_WIDTH > TICKS_WIDTH) ? COUNT_WIDTH : TICKS_WIDTH;
  localparam logic [CMP_WIDTH-1:0] COUNT_MAX = CMP_WIDTH'((1 << COUNT_WIDTH) - 1);

  // Configuration port widths.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 8;

  // Register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SP_LOW  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SP_HIGH = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OK_LOW  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_OK_HIGH = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PG_LOW  = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PG_HIGH = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FORCE   = 3'd6;

  // Register reset values.
  localparam logic [TICKS_WIDTH-1:0] SP_TICKS_RST = 8'd2;
  localparam logic [TICKS_WIDTH-1:0] OK_TICKS_RST = 8'd1;
  localparam logic [TICKS_WIDTH-1:0] PG_TICKS_RST = 8'd2;

  // Item kinds.
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_IRQ  = 1'b1;

  // Efuse power good commands.
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_RESET   = 2'd1;
  localparam logic [1:0] CMD_DISABLE = 2'd2;

  // Register bank contents.
  typedef struct packed {
    logic [TICKS_WIDTH-1:0] sp_low;
    logic [TICKS_WIDTH-1:0] sp_high;
    logic [TICKS_WIDTH-1:0] ok_low;
    logic [TICKS_WIDTH-1:0] ok_high;
    logic [TICKS_WIDTH-1:0] pg_low;
    logic [TICKS_WIDTH-1:0] pg_high;
    logic                   force_on;
  } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/dppe_if.sv @@
// ----------------------------------------------------------------------------
// dppe channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface dppe_in_if;
  logic valid;
  logic ready;
  logic func;
  logic system_present_in;
  logic charge_ok_in;
  logic efuse_pg_in;

  modport source (output valid, func, system_present_in, charge_ok_in, efuse_pg_in,
                  input ready);
  modport sink (input valid, func, system_present_in, charge_ok_in, efuse_pg_in,
                output ready);
endinterface

interface dppe_out_if;
  logic       valid;
  logic       ready;
  logic       output_on;
  logic       ready_led;
  logic       powering_led;
  logic [1:0] efuse_pg_cmd;
  logic       system_present_level;
  logic       charge_ok_level;
  logic       efuse_pg_level;

  modport source (output valid, output_on, ready_led, powering_led, efuse_pg_cmd,
                  system_present_level, charge_ok_level, efuse_pg_level,
                  input ready);
  modport sink (input valid, output_on, ready_led, powering_led, efuse_pg_cmd,
                system_present_level, charge_ok_level, efuse_pg_level,
                output ready);
endinterface

interface dppe_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dppe_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [dppe_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dppe_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dppe_cfg_regs: configuration register bank
// Holds the debounce thresholds and the force flag; writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dppe_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  dppe_cfg_if.sink           cfg_ch,
  output dppe_pkg::cfg_t     cfg
);

  dppe_pkg::cfg_t cfg_r;
  dppe_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;
  assign cfg          = cfg_r;

  // Decode the register index; indexes past the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_ch.index)
        dppe_pkg::REG_SP_LOW:  cfg_nxt.sp_low   = cfg_ch.data;
        dppe_pkg::REG_SP_HIGH: cfg_nxt.sp_high  = cfg_ch.data;
        dppe_pkg::REG_OK_LOW:  cfg_nxt.ok_low   = cfg_ch.data;
        dppe_pkg::REG_OK_HIGH: cfg_nxt.ok_high  = cfg_ch.data;
        dppe_pkg::REG_PG_LOW:  cfg_nxt.pg_low   = cfg_ch.data;
        dppe_pkg::REG_PG_HIGH: cfg_nxt.pg_high  = cfg_ch.data;
        dppe_pkg::REG_FORCE:   cfg_nxt.force_on = cfg_ch.data[0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sp_low   <= dppe_pkg::SP_TICKS_RST;
      cfg_r.sp_high  <= dppe_pkg::SP_TICKS_RST;
      cfg_r.ok_low   <= dppe_pkg::OK_TICKS_RST;
      cfg_r.ok_high  <= dppe_pkg::OK_TICKS_RST;
      cfg_r.pg_low   <= dppe_pkg::PG_TICKS_RST;
      cfg_r.pg_high  <= dppe_pkg::PG_TICKS_RST;
      cfg_r.force_on <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/dppe_tracker.sv @@
// ----------------------------------------------------------------------------
// dppe_tracker: asymmetric counter debouncer for one signal
// Keeps a debounced level and a saturating count for each sample level.
// ----------------------------------------------------------------------------
`default_nettype none

module dppe_tracker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             sample,
  input  wire logic [dppe_pkg::TICKS_WIDTH-1:0] min_low,
  input  wire logic [dppe_pkg::TICKS_WIDTH-1:0] min_high,
  output logic                                  level,
  output logic                                  level_nxt
);

  logic [dppe_pkg::COUNT_WIDTH-1:0] lo_cnt_r, lo_cnt_nxt;
  logic [dppe_pkg::COUNT_WIDTH-1:0] hi_cnt_r, hi_cnt_nxt;
  logic                             level_r;
  logic [dppe_pkg::CMP_WIDTH-1:0]   lim_raw;
  logic [dppe_pkg::CMP_WIDTH-1:0]   lim;
  logic [dppe_pkg::CMP_WIDTH-1:0]   cnt;

  assign level = level_r;

  // Threshold for the sampled level, clamped to the counter range.
  assign lim_raw = sample ? dppe_pkg::CMP_WIDTH'(min_high) : dppe_pkg::CMP_WIDTH'(min_low);
  assign lim     = (lim_raw > dppe_pkg::COUNT_MAX) ? dppe_pkg::COUNT_MAX : lim_raw;
  assign cnt     = sample ? dppe_pkg::CMP_WIDTH'(hi_cnt_r) : dppe_pkg::CMP_WIDTH'(lo_cnt_r);

  // Count up to the threshold, then switch level and clear the other count.
  always_comb begin
    lo_cnt_nxt = lo_cnt_r;
    hi_cnt_nxt = hi_cnt_r;
    level_nxt  = level_r;
    if (en) begin
      if (cnt < lim) begin
        if (sample) begin
          hi_cnt_nxt = hi_cnt_r + dppe_pkg::COUNT_WIDTH'(1);
        end else begin
          lo_cnt_nxt = lo_cnt_r + dppe_pkg::COUNT_WIDTH'(1);
        end
      end else if (level_r != sample) begin
        level_nxt = sample;
        if (sample) begin
          lo_cnt_nxt = '0;
        end else begin
          hi_cnt_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_cnt_r <= '0;
      hi_cnt_r <= '0;
      level_r  <= 1'b0;
    end else begin
      lo_cnt_r <= lo_cnt_nxt;
      hi_cnt_r <= hi_cnt_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/debounced_power_path_enable_top.sv @@
// Path: an input word is taken into the input register, then moves into the
// result register, from which its result word is offered.
// Throughput: one word per cycle; the input register refills while the
// result register drains, so only output back-pressure stalls the block.
// Reset: synchronous active-low rst_n clears levels, counts, LEDs and the
// output enable, and loads the default thresholds.
// ----------------------------------------------------------------------------
// debounced_power_path_enable_top: debounced power path enable
// Debounces system present, charge ok and efuse power good, and derives the
// output enable, LEDs and efuse command for each tick or efuse interrupt.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_power_path_enable_top (
  input  wire logic    clk,
  input  wire logic    rst_n,
  dppe_in_if.sink      in_ch,
  dppe_out_if.source   out_ch,
  dppe_cfg_if.sink     cfg_ch
);

  dppe_pkg::cfg_t cfg;

  // Input register.
  logic s1_v_r, s1_v_nxt;
  logic func_r, sp_in_r, ok_in_r, pg_in_r;
  // Result register and power path status.
  logic       out_v_r, out_v_nxt;
  logic       output_r, output_nxt;
  logic       ready_led_r, ready_led_nxt;
  logic       powering_r, powering_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  logic in_acc;
  logic adv;
  logic tick;
  logic enable;
  logic sp_lvl, sp_lvl_nxt;
  logic ok_lvl, ok_lvl_nxt;
  logic pg_lvl, pg_lvl_nxt;

  dppe_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Handshake: the stored word moves on when the result register is empty or its word is being taken.
  assign adv         = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign tick        = adv && (func_r == dppe_pkg::FUNC_TICK);

  dppe_tracker u_sp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (tick),
    .sample    (sp_in_r),
    .min_low   (cfg.sp_low),
    .min_high  (cfg.sp_high),
    .level     (sp_lvl),
    .level_nxt (sp_lvl_nxt)
  );

  dppe_tracker u_ok (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (tick),
    .sample    (ok_in_r),
    .min_low   (cfg.ok_low),
    .min_high  (cfg.ok_high),
    .level     (ok_lvl),
    .level_nxt (ok_lvl_nxt)
  );

  dppe_tracker u_pg (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .sample    (pg_in_r),
    .min_low   (cfg.pg_low),
    .min_high  (cfg.pg_high),
    .level     (pg_lvl),
    .level_nxt (pg_lvl_nxt)
  );

  // Output enable, LEDs and efuse command for the word being finished.
  assign enable = (sp_lvl_nxt & ok_lvl_nxt) | cfg.force_on;

  always_comb begin
    output_nxt    = output_r;
    ready_led_nxt = ready_led_r;
    powering_nxt  = powering_r;
    cmd_nxt       = cmd_r;
    if (adv) begin
      cmd_nxt = dppe_pkg::CMD_NONE;
      if (func_r == dppe_pkg::FUNC_TICK) begin
        ready_led_nxt = ok_lvl_nxt;
        output_nxt    = enable;
        powering_nxt  = enable;
        cmd_nxt       = enable ? dppe_pkg::CMD_RESET : dppe_pkg::CMD_DISABLE;
      end else if (!pg_lvl_nxt) begin
        output_nxt   = 1'b0;
        powering_nxt = 1'b0;
      end
    end
  end

  // Valid flags of both stages.
  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      output_r    <= 1'b0;
      ready_led_r <= 1'b0;
      powering_r  <= 1'b0;
      cmd_r       <= dppe_pkg::CMD_NONE;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_v_r     <= out_v_nxt;
      output_r    <= output_nxt;
      ready_led_r <= ready_led_nxt;
      powering_r  <= powering_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  // Input word payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r  <= in_ch.func;
      sp_in_r <= in_ch.system_present_in;
      ok_in_r <= in_ch.charge_ok_in;
      pg_in_r <= in_ch.efuse_pg_in;
    end
  end

  // The status registers only change when a word enters the result stage,
  // so they hold the pending result word's values.
  assign out_ch.valid                = out_v_r;
  assign out_ch.output_on            = output_r;
  assign out_ch.ready_led            = ready_led_r;
  assign out_ch.powering_led         = powering_r;
  assign out_ch.efuse_pg_cmd         = cmd_r;
  assign out_ch.system_present_level = sp_lvl;
  assign out_ch.charge_ok_level      = ok_lvl;
  assign out_ch.efuse_pg_level       = pg_lvl;

endmodule

`default_nettype wire
